### rtl/core/cdt_pkg.sv
package cdt_pkg;

  localparam int unsigned LapSlots = 6;
  localparam int unsigned LapIdxW  = (LapSlots > 1) ? $clog2(LapSlots) : 1;
  localparam int unsigned LapCntW  = $clog2(LapSlots + 1);

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 19;

  localparam logic [18:0] SetMin      = 19'd10;
  localparam logic [18:0] SetMax      = 19'd359999;
  localparam logic [18:0] SetReset    = 19'd300;
  localparam logic [15:0] TimeoutRst  = 16'd60000;
  localparam logic [16:0] AgeMax      = 17'd131071;
  localparam logic [28:0] MsPerSec    = 29'd1000;
  localparam logic [18:0] StepSmall   = 19'd10;
  localparam logic [18:0] StepLarge   = 19'd60;

  typedef enum logic [1:0] {
    ModeTick     = 2'd0,
    ModeTimerBtn = 2'd1,
    ModeSwBtn    = 2'd2,
    ModeAdjust   = 2'd3
  } cdt_mode_e;

  typedef enum logic [1:0] {
    SlotPrimary   = 2'd0,
    SlotSecondary = 2'd1,
    SlotClear     = 2'd2,
    SlotUnused    = 2'd3
  } cdt_slot_e;

  typedef enum logic [1:0] {
    AdjMinus60 = 2'd0,
    AdjMinus10 = 2'd1,
    AdjPlus10  = 2'd2,
    AdjPlus60  = 2'd3
  } cdt_adj_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegDefaultSet   = 1'd0,
    RegAlarmTimeout = 1'd1
  } cdt_reg_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  slot;
    logic [15:0] delta_ms;
    logic [2:0]  lap_select;
  } cdt_in_t;

  typedef struct packed {
    logic [28:0] remaining_ms;
    logic [18:0] set_seconds;
    logic        timer_active;
    logic        alarm_active;
    logic        alarm_fired;
    logic [31:0] stopwatch_ms;
    logic        stopwatch_active;
    logic [2:0]  laps_recorded;
    logic [31:0] lap_value;
  } cdt_out_t;

  typedef struct packed {
    logic [18:0] default_set;
    logic [15:0] alarm_timeout;
  } cdt_cfg_t;

  typedef struct packed {
    logic [18:0]        timer_set;
    logic [28:0]        timer_left;
    logic               timer_run;
    logic               alarm_on;
    logic [16:0]        alarm_age;
    logic [31:0]        sw_total;
    logic               sw_run;
    logic [LapCntW-1:0] lap_count;
  } cdt_state_t;

  typedef struct packed {
    logic               we;
    logic [LapIdxW-1:0] addr;
    logic [31:0]        data;
  } cdt_lap_wr_t;

endpackage

### rtl/core/cdt_step.sv
module cdt_step (
  input  cdt_pkg::cdt_state_t  state_i,
  input  cdt_pkg::cdt_cfg_t    cfg_i,
  input  cdt_pkg::cdt_in_t     item_i,
  input  logic [31:0]          lap_rd_i,
  output cdt_pkg::cdt_state_t  state_o,
  output cdt_pkg::cdt_lap_wr_t lap_wr_o,
  output cdt_pkg::cdt_out_t    result_o
);
  import cdt_pkg::*;

  logic [28:0] reload;
  logic [17:0] age_sum;
  logic [16:0] age_sat;
  logic [18:0] adj_step;
  logic [18:0] default_clamped;
  logic        fired;
  logic        lap_hit;

  assign reload  = {10'd0, state_i.timer_set} * MsPerSec;
  assign age_sum = {1'b0, state_i.alarm_age} + {2'd0, item_i.delta_ms};
  assign age_sat = age_sum[17] ? AgeMax : age_sum[16:0];

  always_comb begin
    if (cfg_i.default_set < SetMin) begin
      default_clamped = SetMin;
    end else if (cfg_i.default_set > SetMax) begin
      default_clamped = SetMax;
    end else begin
      default_clamped = cfg_i.default_set;
    end
  end

  always_comb begin
    case (cdt_adj_e'(item_i.slot))
      AdjMinus60, AdjPlus60: adj_step = StepLarge;
      default:               adj_step = StepSmall;
    endcase
  end

  always_comb begin
    state_o  = state_i;
    fired    = 1'b0;
    lap_wr_o = '{we: 1'b0, addr: LapIdxW'(state_i.lap_count), data: state_i.sw_total};

    case (cdt_mode_e'(item_i.mode))
      ModeTick: begin
        if (state_i.alarm_on) begin
          state_o.alarm_age = age_sat;
          if (age_sat > {1'b0, cfg_i.alarm_timeout}) begin
            state_o.alarm_on   = 1'b0;
            state_o.timer_left = reload;
          end
        end else if (state_i.timer_run) begin
          if ({13'd0, item_i.delta_ms} >= state_i.timer_left) begin
            state_o.timer_left = '0;
            state_o.timer_run  = 1'b0;
            state_o.alarm_on   = 1'b1;
            state_o.alarm_age  = '0;
            fired              = 1'b1;
          end else begin
            state_o.timer_left = state_i.timer_left - {13'd0, item_i.delta_ms};
          end
        end
        if (state_i.sw_run) begin
          state_o.sw_total = state_i.sw_total + {16'd0, item_i.delta_ms};
        end
      end
      ModeTimerBtn: begin
        if (state_i.alarm_on) begin
          if (cdt_slot_e'(item_i.slot) == SlotSecondary) begin
            state_o.alarm_on   = 1'b0;
            state_o.timer_left = reload;
          end
        end else if (state_i.timer_run) begin
          if (cdt_slot_e'(item_i.slot) == SlotPrimary) begin
            state_o.timer_run = 1'b0;
          end else if (cdt_slot_e'(item_i.slot) == SlotClear) begin
            state_o.timer_run  = 1'b0;
            state_o.timer_left = reload;
          end
        end else begin
          if (cdt_slot_e'(item_i.slot) == SlotPrimary) begin
            if (state_i.timer_left == '0) begin
              state_o.timer_left = reload;
            end
            state_o.timer_run = 1'b1;
          end else if (cdt_slot_e'(item_i.slot) == SlotClear) begin
            state_o.timer_left = '0;
            state_o.timer_set  = default_clamped;
          end
        end
      end
      ModeSwBtn: begin
        case (cdt_slot_e'(item_i.slot))
          SlotPrimary: state_o.sw_run = !state_i.sw_run;
          SlotSecondary: begin
            if (state_i.sw_run && (32'(state_i.lap_count) < 32'(LapSlots))) begin
              lap_wr_o.we       = 1'b1;
              state_o.lap_count = state_i.lap_count + LapCntW'(1);
            end
          end
          SlotClear: begin
            state_o.sw_run    = 1'b0;
            state_o.sw_total  = '0;
            state_o.lap_count = '0;
          end
          default: ;
        endcase
      end
      default: begin
        if (!state_i.timer_run && !state_i.alarm_on) begin
          case (cdt_adj_e'(item_i.slot))
            AdjMinus60, AdjMinus10: begin
              if (state_i.timer_set < SetMin + adj_step) begin
                state_o.timer_set = SetMin;
              end else begin
                state_o.timer_set = state_i.timer_set - adj_step;
              end
            end
            default: begin
              if (state_i.timer_set > SetMax - adj_step) begin
                state_o.timer_set = SetMax;
              end else begin
                state_o.timer_set = state_i.timer_set + adj_step;
              end
            end
          endcase
        end
      end
    endcase
  end

  assign lap_hit = 32'(item_i.lap_select) < 32'(state_o.lap_count);

  always_comb begin
    result_o.remaining_ms     = state_o.timer_left;
    result_o.set_seconds      = state_o.timer_set;
    result_o.timer_active     = state_o.timer_run;
    result_o.alarm_active     = state_o.alarm_on;
    result_o.alarm_fired      = fired;
    result_o.stopwatch_ms     = state_o.sw_total;
    result_o.stopwatch_active = state_o.sw_run;
    result_o.laps_recorded    = 3'(state_o.lap_count);
    if (!lap_hit) begin
      result_o.lap_value = '0;
    end else if (lap_wr_o.we
                 && (32'(item_i.lap_select) == 32'(state_i.lap_count))) begin
      result_o.lap_value = state_i.sw_total;
    end else begin
      result_o.lap_value = lap_rd_i;
    end
  end

endmodule

### rtl/core/countdown_timer_and_lap_stopwatch_unit.sv
// An accepted transaction is held in the input register; its result is then
// registered in the result register. Throughput: one transaction per cycle while
// results are taken; the two registers let a new item in while a result still waits.
// Reset clears the timer, alarm, stopwatch, lap count and handshake state and
// loads both configuration registers with their defaults; the lap store is not reset.
module countdown_timer_and_lap_stopwatch_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cdt_pkg::cdt_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cdt_pkg::cdt_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [cdt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cdt_pkg::CfgDataW-1:0]  cfg_data_i
);
  import cdt_pkg::*;

  cdt_in_t     in_q;
  logic        in_valid_q;
  cdt_out_t    out_q;
  logic        out_valid_q;
  cdt_cfg_t    cfg_q;
  cdt_state_t  state_q;
  cdt_state_t  state_d;
  cdt_out_t    out_d;
  cdt_lap_wr_t lap_wr;
  logic [31:0] lap_store_q [LapSlots];
  logic [31:0] lap_rd;
  logic        advance;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign lap_rd = (32'(in_q.lap_select) < 32'(LapSlots))
                  ? lap_store_q[LapIdxW'(in_q.lap_select)] : '0;

  cdt_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (in_q),
    .lap_rd_i (lap_rd),
    .state_o  (state_d),
    .lap_wr_o (lap_wr),
    .result_o (out_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.default_set   <= SetReset;
      cfg_q.alarm_timeout <= TimeoutRst;
    end else if (cfg_we_i) begin
      case (cdt_reg_e'(cfg_index_i))
        RegDefaultSet:   cfg_q.default_set   <= cfg_data_i[18:0];
        RegAlarmTimeout: cfg_q.alarm_timeout <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{timer_set: SetReset, default: '0};
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
    if (advance && lap_wr.we) begin
      lap_store_q[lap_wr.addr] <= lap_wr.data;
    end
  end

  a_fired_raises_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.alarm_fired
      |-> out_data_o.alarm_active && !out_data_o.timer_active
          && (out_data_o.remaining_ms == '0))
    else $error("alarm fired without a stopped, expired timer");

  a_run_excludes_alarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.timer_run && state_q.alarm_on))
    else $error("timer running while the alarm is pending");

  a_lap_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(state_q.lap_count) <= 32'(LapSlots))
    else $error("lap count beyond the store depth");

  a_set_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.timer_set >= SetMin) && (state_q.timer_set <= SetMax))
    else $error("set time out of range");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(state_q))
    else $error("state advanced while a result was stalled");

endmodule
